### rtl/tagged_packet_fifo_with_stats_macros.svh
// Assertion macros for the tagged packet FIFO checker.
// Included by the checker file only; no other dependencies.
`ifndef TAGGED_PACKET_FIFO_WITH_STATS_MACROS_SVH
`define TAGGED_PACKET_FIFO_WITH_STATS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPFS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpfs checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define TPFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpfs checker: next-cycle property failed");

`endif

### rtl/tpfs_pkg.sv
// Shared types, codes and default sizes for the tagged packet FIFO.
// No dependencies; the interface, RAM, stats, controller, top and checker files refer to it by scoped names.
`default_nettype none

package tpfs_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int BUFFER_BYTES_DEF   = 4096;
  localparam int MAX_PACKETS_DEF    = 16;
  localparam int MAX_PACKET_LEN_DEF = 2047;

  // Fixed field widths.
  localparam int ACTION_W  = 2;
  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 11;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 32;
  localparam int QLEN_W    = 5;
  localparam int DESC_W    = PLEN_W + 1;
  // Width wide enough to compare a length against a maximum length of up to 131071.
  localparam int LEN_CMP_W = 17;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_PULL   = 2'd1,
    ACT_STATUS = 2'd2
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_OK   = 3'd0,
    KIND_PUSH_DROP = 3'd1,
    KIND_DATA      = 3'd2,
    KIND_EMPTY     = 3'd3,
    KIND_STATUS    = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_PULL = 1'b1
  } state_t;

  // Counter update requests from the controller.
  typedef struct packed {
    logic              commit;
    logic [PLEN_W-1:0] commit_bytes;
    logic              pull_fin;
    logic [PLEN_W-1:0] pull_bytes;
    logic              drop;
  } stats_ev_t;

  typedef struct packed {
    logic [STAT_W-1:0] packets_in;
    logic [STAT_W-1:0] packets_out;
    logic [STAT_W-1:0] bytes_in;
    logic [STAT_W-1:0] bytes_out;
    logic [STAT_W-1:0] drops;
  } stats_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] out_byte;
    logic              out_direction;
    logic              last_out;
    stats_t            stats;
    logic [QLEN_W-1:0] queue_length;
    logic [QLEN_W-1:0] queue_peak;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/tpfs_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on tpfs_pkg for field widths.
`default_nettype none

interface tpfs_req_if;
  logic                          valid;
  logic                          ready;
  logic [tpfs_pkg::ACTION_W-1:0] action;
  logic [tpfs_pkg::BYTE_W-1:0]   data_byte;
  logic [tpfs_pkg::PLEN_W-1:0]   packet_length;
  logic                          direction;
  logic                          last_in;

  modport source (output valid, action, data_byte, packet_length, direction, last_in,
                  input ready);
  modport sink (input valid, action, data_byte, packet_length, direction, last_in,
                output ready);
endinterface

interface tpfs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tpfs_pkg::KIND_W-1:0] kind;
  logic [tpfs_pkg::BYTE_W-1:0] out_byte;
  logic                        out_direction;
  logic                        last_out;
  logic [tpfs_pkg::STAT_W-1:0] packets_in;
  logic [tpfs_pkg::STAT_W-1:0] packets_out;
  logic [tpfs_pkg::STAT_W-1:0] bytes_in;
  logic [tpfs_pkg::STAT_W-1:0] bytes_out;
  logic [tpfs_pkg::STAT_W-1:0] drops;
  logic [tpfs_pkg::QLEN_W-1:0] queue_length;
  logic [tpfs_pkg::QLEN_W-1:0] queue_peak;

  modport source (output valid, kind, out_byte, out_direction, last_out, packets_in,
                  packets_out, bytes_in, bytes_out, drops, queue_length, queue_peak,
                  input ready);
  modport sink (input valid, kind, out_byte, out_direction, last_out, packets_in,
                packets_out, bytes_in, bytes_out, drops, queue_length, queue_peak,
                output ready);
endinterface

`default_nettype wire

### rtl/tpfs_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on tpfs_pkg for default sizes.
`default_nettype none

module tpfs_ram #(
  parameter int DEPTH = tpfs_pkg::BUFFER_BYTES_DEF,
  parameter int WIDTH = tpfs_pkg::BYTE_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/tpfs_stats.sv
// Wrapping 32-bit statistics counters for packets, bytes and drops.
// Depends on tpfs_pkg for the event and counter structs.
`default_nettype none

module tpfs_stats (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tpfs_pkg::stats_ev_t ev,
  output tpfs_pkg::stats_t         stats
);

  tpfs_pkg::stats_t cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (ev.commit) begin
        cnt.packets_in <= cnt.packets_in + tpfs_pkg::STAT_W'(1);
        cnt.bytes_in   <= cnt.bytes_in + tpfs_pkg::STAT_W'(ev.commit_bytes);
      end
      if (ev.pull_fin) begin
        cnt.packets_out <= cnt.packets_out + tpfs_pkg::STAT_W'(1);
        cnt.bytes_out   <= cnt.bytes_out + tpfs_pkg::STAT_W'(ev.pull_bytes);
      end
      if (ev.drop) begin
        cnt.drops <= cnt.drops + tpfs_pkg::STAT_W'(1);
      end
    end
  end

  assign stats = cnt;

endmodule

`default_nettype wire

### rtl/tpfs_ctrl.sv
// Queue controller: pointers, push admission, pull sequencing, response register.
// Depends on tpfs_pkg and the channel interfaces in tpfs_if.sv.
`default_nettype none

module tpfs_ctrl #(
  parameter int BUFFER_BYTES   = tpfs_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_PACKETS    = tpfs_pkg::MAX_PACKETS_DEF,
  parameter int MAX_PACKET_LEN = tpfs_pkg::MAX_PACKET_LEN_DEF,
  localparam int PTR_W  = $clog2(BUFFER_BYTES),
  localparam int USED_W = $clog2(BUFFER_BYTES + 1),
  localparam int SLOT_W = $clog2(MAX_PACKETS),
  localparam int CNT_W  = $clog2(MAX_PACKETS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tpfs_req_if.sink                           req,
  tpfs_rsp_if.source                         rsp,
  // Byte memory
  output logic                               bram_we,
  output logic [PTR_W-1:0]                   bram_waddr,
  output logic [tpfs_pkg::BYTE_W-1:0]        bram_wdata,
  output logic [PTR_W-1:0]                   bram_raddr,
  input  wire logic [tpfs_pkg::BYTE_W-1:0]   bram_rdata,
  // Descriptor memory
  output logic                               dram_we,
  output logic [SLOT_W-1:0]                  dram_waddr,
  output logic [tpfs_pkg::DESC_W-1:0]        dram_wdata,
  output logic [SLOT_W-1:0]                  dram_raddr,
  input  wire logic [tpfs_pkg::DESC_W-1:0]   dram_rdata,
  // Statistics
  output tpfs_pkg::stats_ev_t                ev,
  input  wire tpfs_pkg::stats_t              stats
);

  localparam int PLEN_W = tpfs_pkg::PLEN_W;
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(BUFFER_BYTES - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_PACKETS - 1);
  localparam logic [CNT_W-1:0]  PKT_MAX   = CNT_W'(MAX_PACKETS);
  localparam logic [USED_W-1:0] BUF_SIZE  = USED_W'(BUFFER_BYTES);
  localparam logic [tpfs_pkg::LEN_CMP_W-1:0] LEN_MAX = tpfs_pkg::LEN_CMP_W'(MAX_PACKET_LEN);

  tpfs_pkg::state_t state, state_next;

  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [USED_W-1:0] bytes_used, bytes_used_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [SLOT_W-1:0] tail, tail_next;
  logic [CNT_W-1:0]  packet_count, packet_count_next;
  logic [CNT_W-1:0]  peak, peak_next;
  logic [PLEN_W-1:0] pull_offset, pull_offset_next;
  logic              push_in_progress, push_in_progress_next;
  logic              dropping, dropping_next;
  logic [PLEN_W-1:0] push_length, push_length_next;
  logic [PLEN_W-1:0] push_count, push_count_next;
  logic              push_dir, push_dir_next;

  logic              out_valid, out_valid_next;
  tpfs_pkg::rsp_t    rsp_q, rsp_next;
  logic              load;

  tpfs_pkg::action_t act;
  logic              accept;
  logic              start;
  logic [PLEN_W-1:0] len_eff;
  logic [USED_W-1:0] free_bytes;
  logic              fits;
  logic              drop_now;
  logic [PLEN_W-1:0] plen_eff;
  logic              pdir_eff;
  logic [PLEN_W-1:0] pcnt_new;
  logic              ends;
  logic [PLEN_W-1:0] d_len;
  logic              d_dir;
  logic [PLEN_W-1:0] off_new;
  logic              fin;
  logic [CNT_W-1:0]  count_inc;

  // One item at a time: the ready term blocks new items while a pull waits on
  // the memory read, so no write can overlap a pending read.
  assign req.ready  = (state == tpfs_pkg::ST_IDLE) && (!out_valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign bram_raddr = rd_ptr;
  assign dram_raddr = head;

  always_comb begin
    act        = tpfs_pkg::action_t'(req.action);
    start      = !push_in_progress;
    len_eff    = (req.packet_length == '0) ? PLEN_W'(1) : req.packet_length;
    free_bytes = BUF_SIZE - bytes_used;
    fits       = (tpfs_pkg::LEN_CMP_W'(len_eff) <= LEN_MAX)
              && (packet_count < PKT_MAX)
              && (free_bytes >= USED_W'(len_eff));
    drop_now   = start ? !fits : dropping;
    plen_eff   = start ? len_eff : push_length;
    pdir_eff   = start ? req.direction : push_dir;
    pcnt_new   = (start ? '0 : push_count) + PLEN_W'(1);
    ends       = req.last_in || (pcnt_new >= plen_eff);
    count_inc  = packet_count + CNT_W'(1);

    d_len      = dram_rdata[PLEN_W-1:0];
    d_dir      = dram_rdata[PLEN_W];
    off_new    = pull_offset + PLEN_W'(1);
    fin        = off_new >= d_len;

    state_next            = state;
    wr_ptr_next           = wr_ptr;
    rd_ptr_next           = rd_ptr;
    bytes_used_next       = bytes_used;
    head_next             = head;
    tail_next             = tail;
    packet_count_next     = packet_count;
    peak_next             = peak;
    pull_offset_next      = pull_offset;
    push_in_progress_next = push_in_progress;
    dropping_next         = dropping;
    push_length_next      = push_length;
    push_count_next       = push_count;
    push_dir_next         = push_dir;

    rsp_next   = '0;
    load       = 1'b0;
    ev         = '0;
    bram_we    = 1'b0;
    bram_waddr = wr_ptr;
    bram_wdata = req.data_byte;
    dram_we    = 1'b0;
    dram_waddr = tail;
    dram_wdata = {pdir_eff, pcnt_new};

    unique case (state)
      tpfs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (act)
            tpfs_pkg::ACT_PUSH: begin
              load                  = 1'b1;
              rsp_next.kind         = drop_now ? tpfs_pkg::KIND_PUSH_DROP
                                               : tpfs_pkg::KIND_PUSH_OK;
              push_in_progress_next = !ends;
              dropping_next         = ends ? 1'b0 : drop_now;
              push_length_next      = plen_eff;
              push_count_next       = pcnt_new;
              push_dir_next         = pdir_eff;
              ev.drop               = start && !fits;
              if (!drop_now) begin
                bram_we         = 1'b1;
                wr_ptr_next     = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
                bytes_used_next = bytes_used + USED_W'(1);
                if (ends) begin
                  dram_we           = 1'b1;
                  tail_next         = (tail == SLOT_LAST) ? '0 : tail + SLOT_W'(1);
                  packet_count_next = count_inc;
                  if (count_inc > peak) begin
                    peak_next = count_inc;
                  end
                  ev.commit       = 1'b1;
                  ev.commit_bytes = pcnt_new;
                end
              end
            end
            tpfs_pkg::ACT_PULL: begin
              if (packet_count == '0) begin
                load          = 1'b1;
                rsp_next.kind = tpfs_pkg::KIND_EMPTY;
              end else begin
                // Byte and descriptor reads are issued at this edge.
                state_next = tpfs_pkg::ST_PULL;
              end
            end
            default: begin
              load                  = 1'b1;
              rsp_next.kind         = tpfs_pkg::KIND_STATUS;
              rsp_next.stats        = stats;
              rsp_next.queue_length = tpfs_pkg::QLEN_W'(packet_count);
              rsp_next.queue_peak   = tpfs_pkg::QLEN_W'(peak);
            end
          endcase
        end
      end
      tpfs_pkg::ST_PULL: begin
        load                   = 1'b1;
        rsp_next.kind          = tpfs_pkg::KIND_DATA;
        rsp_next.out_byte      = bram_rdata;
        rsp_next.out_direction = d_dir;
        rsp_next.last_out      = fin;
        rd_ptr_next            = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
        if (bytes_used != '0) begin
          bytes_used_next = bytes_used - USED_W'(1);
        end
        if (fin) begin
          head_next         = (head == SLOT_LAST) ? '0 : head + SLOT_W'(1);
          packet_count_next = packet_count - CNT_W'(1);
          pull_offset_next  = '0;
          ev.pull_fin       = 1'b1;
          ev.pull_bytes     = d_len;
        end else begin
          pull_offset_next = off_new;
        end
        state_next = tpfs_pkg::ST_IDLE;
      end
      default: begin
        state_next = tpfs_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tpfs_pkg::ST_IDLE;
      wr_ptr           <= '0;
      rd_ptr           <= '0;
      bytes_used       <= '0;
      head             <= '0;
      tail             <= '0;
      packet_count     <= '0;
      peak             <= '0;
      pull_offset      <= '0;
      push_in_progress <= 1'b0;
      dropping         <= 1'b0;
      push_length      <= '0;
      push_count       <= '0;
      push_dir         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      wr_ptr           <= wr_ptr_next;
      rd_ptr           <= rd_ptr_next;
      bytes_used       <= bytes_used_next;
      head             <= head_next;
      tail             <= tail_next;
      packet_count     <= packet_count_next;
      peak             <= peak_next;
      pull_offset      <= pull_offset_next;
      push_in_progress <= push_in_progress_next;
      dropping         <= dropping_next;
      push_length      <= push_length_next;
      push_count       <= push_count_next;
      push_dir         <= push_dir_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.kind          = rsp_q.kind;
  assign rsp.out_byte      = rsp_q.out_byte;
  assign rsp.out_direction = rsp_q.out_direction;
  assign rsp.last_out      = rsp_q.last_out;
  assign rsp.packets_in    = rsp_q.stats.packets_in;
  assign rsp.packets_out   = rsp_q.stats.packets_out;
  assign rsp.bytes_in      = rsp_q.stats.bytes_in;
  assign rsp.bytes_out     = rsp_q.stats.bytes_out;
  assign rsp.drops         = rsp_q.stats.drops;
  assign rsp.queue_length  = rsp_q.queue_length;
  assign rsp.queue_peak    = rsp_q.queue_peak;

endmodule

`default_nettype wire

### rtl/tagged_packet_fifo_with_stats.sv
// Top level of the tagged packet FIFO with statistics.
// Depends on tpfs_pkg, tpfs_if, tpfs_ram, tpfs_stats and tpfs_ctrl.
//
//   Channel  Dir  Carries
//   -------  ---  ---------------------------------------------------------
//   req      in   action, data_byte, packet_length, direction, last_in
//   rsp      out  kind, out_byte, out_direction, last_out, five counters,
//                 queue_length, queue_peak
//
// Push and status beats are answered in the cycle after acceptance; a pull
// from a non-empty queue first passes through ST_PULL, because the byte and
// descriptor memories have a registered read port, and req.ready stays low
// during that read. A pull from an empty queue is answered like a push.
// The response sits in an output register; a new request beat is accepted in
// the same cycle that the waiting response beat is taken by rsp.ready.
// Reset (rst, synchronous, active high) clears pointers, counters and the
// push state; the memory contents are left as they are and need no clearing.
`default_nettype none

module tagged_packet_fifo_with_stats #(
  parameter int BUFFER_BYTES   = tpfs_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_PACKETS    = tpfs_pkg::MAX_PACKETS_DEF,
  parameter int MAX_PACKET_LEN = tpfs_pkg::MAX_PACKET_LEN_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  tpfs_req_if.sink   req,
  tpfs_rsp_if.source rsp
);

  localparam int PTR_W  = $clog2(BUFFER_BYTES);
  localparam int SLOT_W = $clog2(MAX_PACKETS);

  // Byte ring buffer port signals.
  logic                        bram_we;
  logic [PTR_W-1:0]            bram_waddr;
  logic [tpfs_pkg::BYTE_W-1:0] bram_wdata;
  logic [PTR_W-1:0]            bram_raddr;
  logic [tpfs_pkg::BYTE_W-1:0] bram_rdata;

  // Descriptor ring port signals; each entry is {direction, length}.
  logic                        dram_we;
  logic [SLOT_W-1:0]           dram_waddr;
  logic [tpfs_pkg::DESC_W-1:0] dram_wdata;
  logic [SLOT_W-1:0]           dram_raddr;
  logic [tpfs_pkg::DESC_W-1:0] dram_rdata;

  tpfs_pkg::stats_ev_t stats_ev;
  tpfs_pkg::stats_t    stats;

  // The controller owns all pointers and sequencing. It writes a pushed byte
  // in the accept cycle and commits the descriptor when the packet ends, so a
  // packet becomes visible to pulls only once it is complete.
  tpfs_ctrl #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .MAX_PACKETS    (MAX_PACKETS),
    .MAX_PACKET_LEN (MAX_PACKET_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .bram_we    (bram_we),
    .bram_waddr (bram_waddr),
    .bram_wdata (bram_wdata),
    .bram_raddr (bram_raddr),
    .bram_rdata (bram_rdata),
    .dram_we    (dram_we),
    .dram_waddr (dram_waddr),
    .dram_wdata (dram_wdata),
    .dram_raddr (dram_raddr),
    .dram_rdata (dram_rdata),
    .ev         (stats_ev),
    .stats      (stats)
  );

  // Packet bytes, stored as one ring across all packets.
  tpfs_ram #(
    .DEPTH (BUFFER_BYTES),
    .WIDTH (tpfs_pkg::BYTE_W)
  ) u_byte_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bram_waddr),
    .wdata (bram_wdata),
    .raddr (bram_raddr),
    .rdata (bram_rdata)
  );

  // One descriptor per committed packet.
  tpfs_ram #(
    .DEPTH (MAX_PACKETS),
    .WIDTH (tpfs_pkg::DESC_W)
  ) u_desc_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (dram_wdata),
    .raddr (dram_raddr),
    .rdata (dram_rdata)
  );

  // Wrapping counters of packets and bytes in and out, and of drops.
  tpfs_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .ev    (stats_ev),
    .stats (stats)
  );

endmodule

`default_nettype wire

### rtl/tpfs_checker.sv
// Port-level checks on the FIFO response channel, bound to the top level.
// Depends on tpfs_pkg and tagged_packet_fifo_with_stats_macros.svh.
`default_nettype none
`include "tagged_packet_fifo_with_stats_macros.svh"

module tpfs_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [tpfs_pkg::KIND_W-1:0] rsp_kind,
  input wire logic [tpfs_pkg::BYTE_W-1:0] rsp_out_byte,
  input wire logic                        rsp_out_direction,
  input wire logic                        rsp_last_out,
  input wire logic [tpfs_pkg::QLEN_W-1:0] rsp_queue_length,
  input wire logic [tpfs_pkg::QLEN_W-1:0] rsp_queue_peak
);

  // A stalled response beat stays put.
  `TPFS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_last_out))

  // Byte fields are only populated on data beats.
  `TPFS_ASSERT_NOW(a_data_fields_clear, clk, rst, rsp_valid && (rsp_kind != tpfs_pkg::KIND_DATA), (rsp_out_byte == '0) && !rsp_out_direction && !rsp_last_out)

  // Queue fields are only populated on status beats.
  `TPFS_ASSERT_NOW(a_queue_fields_clear, clk, rst, rsp_valid && (rsp_kind != tpfs_pkg::KIND_STATUS), (rsp_queue_length == '0) && (rsp_queue_peak == '0))

endmodule

bind tagged_packet_fifo_with_stats tpfs_checker u_tpfs_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_kind          (rsp.kind),
  .rsp_out_byte      (rsp.out_byte),
  .rsp_out_direction (rsp.out_direction),
  .rsp_last_out      (rsp.last_out),
  .rsp_queue_length  (rsp.queue_length),
  .rsp_queue_peak    (rsp.queue_peak)
);

`default_nettype wire
